/* hw/rtl/tsse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tour swap search evaluator package
// Shared types and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package tsse_pkg;

    localparam int MAX_CITIES = 16;
    localparam int CITY_W     = 4;
    localparam int CNT_W      = 5;
    localparam int DIST_W     = 16;
    localparam int COST_W     = 20;
    localparam int ADDR_W     = 2 * CITY_W;

    localparam logic [CNT_W-1:0]  CNT_RESET = 5'd16;
    localparam logic [CNT_W-1:0]  CNT_MIN   = 5'd2;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 5'd16;
    localparam logic [COST_W-1:0] COST_SAT  = 20'hFFFFF;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_STEP    = 2'd1,
        OP_READ    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_FIRST,
        ST_WALK,
        ST_DRAIN,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic load;
        logic restart;
        logic read;
        logic capture;
        logic swap_rd;
        logic swap_wr;
        logic walk_init;
        logic walk_issue;
        logic eval;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_last;
    } t_dp_status;

endpackage

/* hw/rtl/tsse_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tour swap search controller
// Sequences each step through swap, tour walk and best-tour compare.
// ----------------------------------------------------------------------------
module tsse_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_op,
    input  tsse_pkg::t_dp_status i_status,
    output tsse_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy
);

    tsse_pkg::t_state r_state;
    tsse_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsse_pkg::ST_IDLE: begin
                if (i_start && (tsse_pkg::t_op'(i_op) == tsse_pkg::OP_STEP)) begin
                    n_state = tsse_pkg::ST_SWAP_RD;
                end
            end
            tsse_pkg::ST_SWAP_RD: n_state = tsse_pkg::ST_SWAP_WR;
            tsse_pkg::ST_SWAP_WR: n_state = tsse_pkg::ST_FIRST;
            tsse_pkg::ST_FIRST:   n_state = tsse_pkg::ST_WALK;
            tsse_pkg::ST_WALK: begin
                if (i_status.walk_last) begin
                    n_state = tsse_pkg::ST_DRAIN;
                end
            end
            tsse_pkg::ST_DRAIN:   n_state = tsse_pkg::ST_EVAL;
            tsse_pkg::ST_EVAL:    n_state = tsse_pkg::ST_IDLE;
            default:              n_state = tsse_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            tsse_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    unique case (tsse_pkg::t_op'(i_op))
                        tsse_pkg::OP_LOAD:    o_cmd.load    = 1'b1;
                        tsse_pkg::OP_STEP:    o_cmd.capture = 1'b1;
                        tsse_pkg::OP_READ:    o_cmd.read    = 1'b1;
                        tsse_pkg::OP_RESTART: o_cmd.restart = 1'b1;
                    endcase
                end
            end
            tsse_pkg::ST_SWAP_RD: o_cmd.swap_rd    = 1'b1;
            tsse_pkg::ST_SWAP_WR: o_cmd.swap_wr    = 1'b1;
            tsse_pkg::ST_FIRST:   o_cmd.walk_init  = 1'b1;
            tsse_pkg::ST_WALK:    o_cmd.walk_issue = 1'b1;
            tsse_pkg::ST_DRAIN:   o_cmd            = '0;
            tsse_pkg::ST_EVAL:    o_cmd.eval       = 1'b1;
            default:              o_busy           = 1'b1;
        endcase
    end

endmodule

/* hw/rtl/tsse_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tour swap search datapath
// Distance memory, current and best tours, cost accumulator and result regs.
// ----------------------------------------------------------------------------
module tsse_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tsse_pkg::t_dp_cmd                   i_cmd,
    output tsse_pkg::t_dp_status                o_status,
    input  logic                                i_cfg_valid,
    input  logic [tsse_pkg::CNT_W-1:0]          i_cfg_data,
    input  logic [tsse_pkg::CITY_W-1:0]         i_from_city,
    input  logic [tsse_pkg::CITY_W-1:0]         i_to_city,
    input  logic [tsse_pkg::DIST_W-1:0]         i_distance,
    input  logic [tsse_pkg::CITY_W-1:0]         i_swap_first,
    input  logic [tsse_pkg::CITY_W-1:0]         i_swap_second,
    output logic                                o_strobe,
    output logic [tsse_pkg::COST_W-1:0]         o_tour_cost,
    output logic [tsse_pkg::COST_W-1:0]         o_best_cost,
    output logic                                o_improved,
    output logic [tsse_pkg::CITY_W-1:0]         o_best_city
);

    logic [tsse_pkg::DIST_W-1:0] r_dist_mem [tsse_pkg::MAX_CITIES*tsse_pkg::MAX_CITIES];
    logic [tsse_pkg::CITY_W-1:0] r_tour     [tsse_pkg::MAX_CITIES];
    logic [tsse_pkg::CITY_W-1:0] r_best_tour[tsse_pkg::MAX_CITIES];

    logic [tsse_pkg::CNT_W-1:0]  r_city_count;
    logic [tsse_pkg::CNT_W-1:0]  r_n;
    logic [tsse_pkg::CITY_W-1:0] r_p;
    logic [tsse_pkg::CITY_W-1:0] r_q;
    logic [tsse_pkg::CITY_W-1:0] r_tmp;
    logic [tsse_pkg::CITY_W-1:0] r_first;
    logic [tsse_pkg::CITY_W-1:0] r_prev;
    logic [tsse_pkg::CNT_W-1:0]  r_idx;
    logic [tsse_pkg::DIST_W-1:0] r_rd_data;
    logic                        r_rd_vld;
    logic [tsse_pkg::COST_W-1:0] r_sum;
    logic [tsse_pkg::COST_W-1:0] r_best_len;
    logic                        r_have_best;
    logic                        r_strobe_q;

    logic [tsse_pkg::CNT_W-1:0]  active_n;
    logic                        do_swap;
    logic                        walk_last;
    logic [tsse_pkg::CITY_W-1:0] next_city;
    logic [tsse_pkg::ADDR_W-1:0] rd_addr;
    logic [tsse_pkg::COST_W:0]   sum_wide;
    logic [tsse_pkg::COST_W-1:0] sum_sat;
    logic                        better;

    always_comb begin
        if (r_city_count < tsse_pkg::CNT_MIN) begin
            active_n = tsse_pkg::CNT_MIN;
        end else if (r_city_count > tsse_pkg::CNT_MAX) begin
            active_n = tsse_pkg::CNT_MAX;
        end else begin
            active_n = r_city_count;
        end
    end

    // A swap only happens when both positions lie inside the active tour.
    assign do_swap = ({1'b0, r_p} < r_n) && ({1'b0, r_q} < r_n) && (r_p != r_q);

    // After the last inner edge the walk closes the tour back to the first city.
    assign walk_last = (r_idx == r_n);
    assign next_city = walk_last ? r_first : r_tour[r_idx[tsse_pkg::CITY_W-1:0]];
    assign rd_addr   = {r_prev, next_city};

    assign sum_wide = {1'b0, r_sum} + {{(tsse_pkg::COST_W + 1 - tsse_pkg::DIST_W){1'b0}}, r_rd_data};
    assign sum_sat  = sum_wide[tsse_pkg::COST_W] ? tsse_pkg::COST_SAT
                                                 : sum_wide[tsse_pkg::COST_W-1:0];

    assign better = !r_have_best || (r_sum < r_best_len);

    assign o_status.walk_last = walk_last;

    // Distance memory: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dist_mem[{i_from_city, i_to_city}] <= i_distance;
        end
        r_rd_data <= r_dist_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= tsse_pkg::CNT_RESET;
            for (int k = 0; k < tsse_pkg::MAX_CITIES; k++) begin
                r_tour[k]      <= tsse_pkg::CITY_W'(k);
                r_best_tour[k] <= tsse_pkg::CITY_W'(k);
            end
            r_best_len  <= '0;
            r_have_best <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_strobe_q  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_city_count <= i_cfg_data;
            end
            if (i_cmd.restart) begin
                for (int k = 0; k < tsse_pkg::MAX_CITIES; k++) begin
                    r_tour[k] <= tsse_pkg::CITY_W'(k);
                end
                r_have_best <= 1'b0;
            end
            if (i_cmd.swap_wr && do_swap) begin
                r_tour[r_p] <= r_tour[r_q];
                r_tour[r_q] <= r_tmp;
            end
            r_rd_vld <= i_cmd.walk_issue;
            if (i_cmd.eval && better) begin
                r_best_len  <= r_sum;
                r_have_best <= 1'b1;
                for (int k = 0; k < tsse_pkg::MAX_CITIES; k++) begin
                    r_best_tour[k] <= r_tour[k];
                end
            end
            r_strobe_q <= i_cmd.read || i_cmd.eval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_p <= i_swap_first;
            r_q <= i_swap_second;
            r_n <= active_n;
        end
        if (i_cmd.swap_rd) begin
            r_tmp <= r_tour[r_p];
        end
        if (i_cmd.walk_init) begin
            r_first <= r_tour[0];
            r_prev  <= r_tour[0];
            r_idx   <= tsse_pkg::CNT_W'(1);
            r_sum   <= '0;
        end else begin
            if (i_cmd.walk_issue) begin
                r_prev <= next_city;
                r_idx  <= r_idx + tsse_pkg::CNT_W'(1);
            end
            if (r_rd_vld) begin
                r_sum <= sum_sat;
            end
        end
    end

    // Result registers; the strobe marks the single cycle a result is shown.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            o_tour_cost <= '0;
            o_best_cost <= r_best_len;
            o_improved  <= 1'b0;
            o_best_city <= r_best_tour[i_swap_first];
        end else if (i_cmd.eval) begin
            o_tour_cost <= r_sum;
            o_best_cost <= better ? r_sum : r_best_len;
            o_improved  <= better;
            o_best_city <= '0;
        end
    end

    assign o_strobe = r_strobe_q;

endmodule

/* hw/rtl/tour_swap_search_evaluator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tour swap search evaluator top level
// Load and restart give no result; a read shows its result in the cycle after
// it is accepted. A step walks the tour over the clamped city count and keeps
// busy high until the cycle its result is shown. The receiver cannot stall the
// result. Synchronous active-low reset: tours to identity, city count 16, no
// best tour; the distance table is not cleared.
// ----------------------------------------------------------------------------
module tour_swap_search_evaluator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_op,
    input  logic [tsse_pkg::CITY_W-1:0]  i_from_city,
    input  logic [tsse_pkg::CITY_W-1:0]  i_to_city,
    input  logic [tsse_pkg::DIST_W-1:0]  i_distance,
    input  logic [tsse_pkg::CITY_W-1:0]  i_swap_first,
    input  logic [tsse_pkg::CITY_W-1:0]  i_swap_second,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tsse_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                         o_strobe,
    output logic [tsse_pkg::COST_W-1:0]  o_tour_cost,
    output logic [tsse_pkg::COST_W-1:0]  o_best_cost,
    output logic                         o_improved,
    output logic [tsse_pkg::CITY_W-1:0]  o_best_city
);

    tsse_pkg::t_dp_cmd    dp_cmd;
    tsse_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    tsse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_op),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    tsse_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_from_city   (i_from_city),
        .i_to_city     (i_to_city),
        .i_distance    (i_distance),
        .i_swap_first  (i_swap_first),
        .i_swap_second (i_swap_second),
        .o_strobe      (o_strobe),
        .o_tour_cost   (o_tour_cost),
        .o_best_cost   (o_best_cost),
        .o_improved    (o_improved),
        .o_best_city   (o_best_city)
    );

endmodule
